// ===== hw/rtl/adp_pkg.sv =====
package adp_pkg;

   typedef enum logic [2:0] {
      PH_MAGIC   = 3'd0,
      PH_VERSION = 3'd1,
      PH_FLAGS   = 3'd2,
      PH_NAMELEN = 3'd3,
      PH_NAME    = 3'd4,
      PH_SIZE    = 3'd5,
      PH_TIME    = 3'd6,
      PH_IDLE    = 3'd7
   } phase_type;

   localparam logic [1:0] KIND_NAME_BYTE = 2'd0;
   localparam logic [1:0] KIND_ENTRY     = 2'd1;
   localparam logic [1:0] KIND_DIR_DONE  = 2'd2;
   localparam logic [1:0] KIND_ERROR     = 2'd3;

   localparam logic [1:0] ERR_BAD_MAGIC   = 2'd0;
   localparam logic [1:0] ERR_BAD_VERSION = 2'd1;
   localparam logic [1:0] ERR_TRUNCATED   = 2'd2;

   localparam logic [1:0] CSR_XOR_KEY        = 2'd0;
   localparam logic [1:0] CSR_EXPECTED_MAGIC = 2'd1;
   localparam logic [1:0] CSR_MAX_VERSION    = 2'd2;

   localparam logic [7:0]  XOR_KEY_RESET     = 8'hF7;
   localparam logic [31:0] MAGIC_RESET       = 32'hBAC04AC0;
   localparam logic [31:0] MAX_VERSION_RESET = 32'd0;

   localparam int END_FLAG_BIT = 7;

   localparam logic [2:0] LAST_BYTE_WORD = 3'd3;
   localparam logic [2:0] LAST_BYTE_TIME = 3'd7;

   localparam int CSR_DATA_W = 32;
   localparam int RSP_DATA_W = 176;

   typedef struct packed {
      logic [1:0]         error_code;
      logic [31:0]        header_length;
      logic [63:0]        file_time;
      logic signed [31:0] entry_size;
      logic [31:0]        entry_offset;
      logic [7:0]         name_byte;
      logic [1:0]         kind;
   } rsp_type;

endpackage

// ===== hw/rtl/archive_directory_parser.sv =====
// Each result is registered in the output buffer, in its head or skid register, before it appears on rsp_.
// One request per cycle while req_tready is high; the parse state advances with each accepted request.
// A two-entry result buffer keeps req_tready high while one result waits.
// Reset (synchronous, active high) clears the parser to magic search and
// restores the key, magic and version limit registers to their defaults.
module archive_directory_parser (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,  // data_byte
   input  logic                               req_tlast,  // end_of_input
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // name_byte, entry_offset, entry_size, file_time, header_length, error_code
   output logic [adp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [1:0]                         rsp_tuser,  // kind
   input  logic                               csr_we,
   input  logic [1:0]                         csr_addr,
   input  logic [adp_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic             accept;
   logic             res_valid;
   adp_pkg::rsp_type res;
   adp_pkg::rsp_type out_data;

   assign accept = req_tvalid && req_tready;

   adp_core u_core (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata),
      .accept       (accept),
      .data_byte    (req_tdata),
      .end_of_input (req_tlast),
      .res_valid    (res_valid),
      .res          (res)
   );

   adp_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (res_valid),
      .push_data  (res),
      .push_ready (req_tready),
      .out_valid  (rsp_tvalid),
      .out_data   (out_data),
      .out_ready  (rsp_tready)
   );

   assign rsp_tuser = out_data.kind;
   assign rsp_tdata = {6'd0,
                       out_data.error_code,
                       out_data.header_length,
                       out_data.file_time,
                       out_data.entry_size,
                       out_data.entry_offset,
                       out_data.name_byte};

endmodule

// ===== hw/rtl/adp_core.sv =====
module adp_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [1:0]                         csr_addr,
   input  logic [adp_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                               accept,
   input  logic [7:0]                         data_byte,
   input  logic                               end_of_input,
   output logic                               res_valid,
   output adp_pkg::rsp_type                   res
);

   logic [7:0]  xor_key_ff, xor_key_in;
   logic [31:0] magic_ff, magic_in;
   logic [31:0] max_version_ff, max_version_in;

   adp_pkg::phase_type phase_ff, phase_in;
   logic [2:0]  byte_pos_ff, byte_pos_in;
   logic [7:0]  name_rem_ff, name_rem_in;
   logic [63:0] shift_ff, shift_in;
   logic [31:0] size_hold_ff, size_hold_in;
   logic [31:0] run_off_ff, run_off_in;
   logic [31:0] consumed_ff, consumed_in;

   logic [7:0]  d;
   logic [63:0] gathered;
   logic [7:0]  name_dec;
   logic [31:0] consumed_inc;

   always_comb begin
      xor_key_in     = xor_key_ff;
      magic_in       = magic_ff;
      max_version_in = max_version_ff;
      if (csr_we) begin
         case (csr_addr)
            adp_pkg::CSR_XOR_KEY:        xor_key_in     = csr_wdata[7:0];
            adp_pkg::CSR_EXPECTED_MAGIC: magic_in       = csr_wdata[31:0];
            adp_pkg::CSR_MAX_VERSION:    max_version_in = csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   assign d            = data_byte ^ xor_key_ff;
   assign name_dec     = name_rem_ff - 8'd1;
   assign consumed_inc = consumed_ff + 32'd1;

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         gathered[i*8 +: 8] = (byte_pos_ff == 3'(i)) ? (shift_ff[i*8 +: 8] | d)
                                                     : shift_ff[i*8 +: 8];
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      byte_pos_in  = byte_pos_ff;
      name_rem_in  = name_rem_ff;
      shift_in     = shift_ff;
      size_hold_in = size_hold_ff;
      run_off_in   = run_off_ff;
      consumed_in  = consumed_ff;
      res_valid    = 1'b0;
      res          = '0;

      if (accept && end_of_input) begin
         if (phase_ff == adp_pkg::PH_FLAGS) begin
            res_valid         = 1'b1;
            res.kind          = adp_pkg::KIND_DIR_DONE;
            res.header_length = consumed_ff;
         end else if (phase_ff != adp_pkg::PH_IDLE &&
                      !(phase_ff == adp_pkg::PH_MAGIC && consumed_ff == 32'd0)) begin
            res_valid      = 1'b1;
            res.kind       = adp_pkg::KIND_ERROR;
            res.error_code = adp_pkg::ERR_TRUNCATED;
         end
         phase_in     = adp_pkg::PH_MAGIC;
         byte_pos_in  = '0;
         name_rem_in  = '0;
         shift_in     = '0;
         size_hold_in = '0;
         run_off_in   = '0;
         consumed_in  = '0;
      end else if (accept && phase_ff != adp_pkg::PH_IDLE) begin
         consumed_in = consumed_inc;
         case (phase_ff)
            adp_pkg::PH_MAGIC, adp_pkg::PH_VERSION, adp_pkg::PH_SIZE: begin
               if (byte_pos_ff == adp_pkg::LAST_BYTE_WORD) begin
                  byte_pos_in = '0;
                  shift_in    = '0;
                  if (phase_ff == adp_pkg::PH_MAGIC) begin
                     if (gathered[31:0] != magic_ff) begin
                        phase_in       = adp_pkg::PH_IDLE;
                        res_valid      = 1'b1;
                        res.kind       = adp_pkg::KIND_ERROR;
                        res.error_code = adp_pkg::ERR_BAD_MAGIC;
                     end else begin
                        phase_in = adp_pkg::PH_VERSION;
                     end
                  end else if (phase_ff == adp_pkg::PH_VERSION) begin
                     if (gathered[31:0] > max_version_ff) begin
                        phase_in       = adp_pkg::PH_IDLE;
                        res_valid      = 1'b1;
                        res.kind       = adp_pkg::KIND_ERROR;
                        res.error_code = adp_pkg::ERR_BAD_VERSION;
                     end else begin
                        run_off_in = '0;
                        phase_in   = adp_pkg::PH_FLAGS;
                     end
                  end else begin
                     size_hold_in = gathered[31:0];
                     phase_in     = adp_pkg::PH_TIME;
                  end
               end else begin
                  byte_pos_in = byte_pos_ff + 3'd1;
                  shift_in    = gathered;
               end
            end
            adp_pkg::PH_FLAGS: begin
               if (d[adp_pkg::END_FLAG_BIT]) begin
                  phase_in          = adp_pkg::PH_IDLE;
                  res_valid         = 1'b1;
                  res.kind          = adp_pkg::KIND_DIR_DONE;
                  res.header_length = consumed_inc;
               end else begin
                  phase_in = adp_pkg::PH_NAMELEN;
               end
            end
            adp_pkg::PH_NAMELEN: begin
               name_rem_in = d;
               byte_pos_in = '0;
               shift_in    = '0;
               phase_in    = (d == 8'd0) ? adp_pkg::PH_SIZE : adp_pkg::PH_NAME;
            end
            adp_pkg::PH_NAME: begin
               name_rem_in = name_dec;
               if (name_dec == 8'd0) begin
                  phase_in = adp_pkg::PH_SIZE;
               end
               res_valid     = 1'b1;
               res.kind      = adp_pkg::KIND_NAME_BYTE;
               res.name_byte = d;
            end
            adp_pkg::PH_TIME: begin
               if (byte_pos_ff == adp_pkg::LAST_BYTE_TIME) begin
                  byte_pos_in      = '0;
                  shift_in         = '0;
                  res_valid        = 1'b1;
                  res.kind         = adp_pkg::KIND_ENTRY;
                  res.entry_offset = run_off_ff;
                  res.entry_size   = size_hold_ff;
                  res.file_time    = gathered;
                  run_off_in       = run_off_ff + size_hold_ff;
                  phase_in         = adp_pkg::PH_FLAGS;
               end else begin
                  byte_pos_in = byte_pos_ff + 3'd1;
                  shift_in    = gathered;
               end
            end
            default: begin
               phase_in = adp_pkg::PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         xor_key_ff     <= adp_pkg::XOR_KEY_RESET;
         magic_ff       <= adp_pkg::MAGIC_RESET;
         max_version_ff <= adp_pkg::MAX_VERSION_RESET;
         phase_ff       <= adp_pkg::PH_MAGIC;
         byte_pos_ff    <= '0;
         name_rem_ff    <= '0;
         shift_ff       <= '0;
         size_hold_ff   <= '0;
         run_off_ff     <= '0;
         consumed_ff    <= '0;
      end else begin
         xor_key_ff     <= xor_key_in;
         magic_ff       <= magic_in;
         max_version_ff <= max_version_in;
         phase_ff       <= phase_in;
         byte_pos_ff    <= byte_pos_in;
         name_rem_ff    <= name_rem_in;
         shift_ff       <= shift_in;
         size_hold_ff   <= size_hold_in;
         run_off_ff     <= run_off_in;
         consumed_ff    <= consumed_in;
      end
   end

endmodule

// ===== hw/rtl/adp_out_buf.sv =====
module adp_out_buf (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  adp_pkg::rsp_type push_data,
   output logic             push_ready,
   output logic             out_valid,
   output adp_pkg::rsp_type out_data,
   input  logic             out_ready
);

   logic             head_valid_ff, head_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   adp_pkg::rsp_type head_ff, head_in;
   adp_pkg::rsp_type skid_ff, skid_in;
   logic             pop;

   assign pop        = head_valid_ff && out_ready;
   assign push_ready = !skid_valid_ff;
   assign out_valid  = head_valid_ff;
   assign out_data   = head_ff;

   always_comb begin
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      head_in       = head_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            head_in       = skid_ff;
            skid_valid_in = push;
            skid_in       = push_data;
         end else begin
            head_valid_in = push;
            head_in       = push_data;
         end
      end else if (push) begin
         if (!head_valid_ff) begin
            head_valid_in = 1'b1;
            head_in       = push_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

endmodule

// ===== tb/archive_directory_parser_tb.sv =====
module archive_directory_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] data;
      logic       eoi;
   } byte_request_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [7:0]                     req_tdata = '0;  // data_byte
   logic                           req_tlast = 1'b0;  // end_of_input
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   // name_byte, entry_offset, entry_size, file_time, header_length, error_code
   logic [adp_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]                     rsp_tuser;  // kind
   logic                           csr_we = 1'b0;
   logic [1:0]                     csr_addr = '0;
   logic [adp_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   archive_directory_parser u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   byte_request_type    pending_requests[$];
   byte_request_type    archive_bytes[$];
   adp_pkg::rsp_type    expected_results[$];
   int                  send_idle_pct = 0;
   int                  recv_stall_pct = 0;
   int                  mismatch_count = 0;

   // register copies
   logic [7:0]          cfg_key = adp_pkg::XOR_KEY_RESET;
   logic [31:0]         cfg_magic = adp_pkg::MAGIC_RESET;
   logic [31:0]         cfg_max_ver = adp_pkg::MAX_VERSION_RESET;

   // parser state
   adp_pkg::phase_type  prs_phase = adp_pkg::PH_MAGIC;
   logic [2:0]          prs_pos = '0;
   logic [7:0]          prs_name_left = '0;
   logic [63:0]         prs_field = '0;
   logic [31:0]         prs_size = '0;
   logic [31:0]         prs_offset = '0;
   logic [31:0]         prs_consumed = '0;

   function automatic void clear_parser();
      prs_phase = adp_pkg::PH_MAGIC;
      prs_pos = '0;
      prs_name_left = '0;
      prs_field = '0;
      prs_size = '0;
      prs_offset = '0;
      prs_consumed = '0;
   endfunction

   // little-endian field accumulate; 1 when the last byte is in
   function automatic logic shift_in(input logic [7:0] d, input logic [2:0] last_pos);
      prs_field = prs_field | (64'(d) << (8 * prs_pos));
      if (prs_pos == last_pos) begin
         prs_pos = '0;
         return 1'b1;
      end
      prs_pos = prs_pos + 3'd1;
      return 1'b0;
   endfunction

   function automatic void parse_request(input logic [7:0] raw, input logic eoi);
      adp_pkg::rsp_type r;
      logic [7:0]       d;
      logic             emit;
      r = '0;
      emit = 1'b0;
      if (eoi) begin
         if (prs_phase == adp_pkg::PH_FLAGS) begin
            r.kind = adp_pkg::KIND_DIR_DONE;
            r.header_length = prs_consumed;
            emit = 1'b1;
         end else if (prs_phase != adp_pkg::PH_IDLE &&
                      !(prs_phase == adp_pkg::PH_MAGIC && prs_consumed == 0)) begin
            r.kind = adp_pkg::KIND_ERROR;
            r.error_code = adp_pkg::ERR_TRUNCATED;
            emit = 1'b1;
         end
         clear_parser();
      end else if (prs_phase != adp_pkg::PH_IDLE) begin
         d = raw ^ cfg_key;
         prs_consumed = prs_consumed + 32'd1;
         case (prs_phase)
            adp_pkg::PH_MAGIC: begin
               if (shift_in(d, adp_pkg::LAST_BYTE_WORD)) begin
                  if (prs_field[31:0] != cfg_magic) begin
                     prs_phase = adp_pkg::PH_IDLE;
                     r.kind = adp_pkg::KIND_ERROR;
                     r.error_code = adp_pkg::ERR_BAD_MAGIC;
                     emit = 1'b1;
                  end else begin
                     prs_phase = adp_pkg::PH_VERSION;
                  end
                  prs_field = '0;
               end
            end
            adp_pkg::PH_VERSION: begin
               if (shift_in(d, adp_pkg::LAST_BYTE_WORD)) begin
                  if (prs_field[31:0] > cfg_max_ver) begin
                     prs_phase = adp_pkg::PH_IDLE;
                     r.kind = adp_pkg::KIND_ERROR;
                     r.error_code = adp_pkg::ERR_BAD_VERSION;
                     emit = 1'b1;
                  end else begin
                     prs_offset = '0;
                     prs_phase = adp_pkg::PH_FLAGS;
                  end
                  prs_field = '0;
               end
            end
            adp_pkg::PH_FLAGS: begin
               if (d[adp_pkg::END_FLAG_BIT]) begin
                  prs_phase = adp_pkg::PH_IDLE;
                  r.kind = adp_pkg::KIND_DIR_DONE;
                  r.header_length = prs_consumed;
                  emit = 1'b1;
               end else begin
                  prs_phase = adp_pkg::PH_NAMELEN;
               end
            end
            adp_pkg::PH_NAMELEN: begin
               prs_name_left = d;
               prs_pos = '0;
               prs_field = '0;
               prs_phase = (d == 8'd0) ? adp_pkg::PH_SIZE : adp_pkg::PH_NAME;
            end
            adp_pkg::PH_NAME: begin
               prs_name_left = prs_name_left - 8'd1;
               if (prs_name_left == 8'd0)
                  prs_phase = adp_pkg::PH_SIZE;
               r.kind = adp_pkg::KIND_NAME_BYTE;
               r.name_byte = d;
               emit = 1'b1;
            end
            adp_pkg::PH_SIZE: begin
               if (shift_in(d, adp_pkg::LAST_BYTE_WORD)) begin
                  prs_size = prs_field[31:0];
                  prs_field = '0;
                  prs_phase = adp_pkg::PH_TIME;
               end
            end
            adp_pkg::PH_TIME: begin
               if (shift_in(d, adp_pkg::LAST_BYTE_TIME)) begin
                  r.kind = adp_pkg::KIND_ENTRY;
                  r.entry_offset = prs_offset;
                  r.entry_size = prs_size;
                  r.file_time = prs_field;
                  emit = 1'b1;
                  prs_field = '0;
                  prs_offset = prs_offset + prs_size;
                  prs_phase = adp_pkg::PH_FLAGS;
               end
            end
            default: prs_phase = adp_pkg::PH_IDLE;
         endcase
      end
      if (emit)
         expected_results.insert(expected_results.size(), r);
   endfunction

   // request driver
   always @(posedge clock) begin
      byte_request_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            item = pending_requests.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= item.data;
            req_tlast <= item.eoi;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // monitor and checker
   always @(posedge clock) begin
      adp_pkg::rsp_type got;
      adp_pkg::rsp_type want;
      if (!reset) begin
         if (req_tvalid && req_tready)
            parse_request(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            got.kind = rsp_tuser;
            got.name_byte = rsp_tdata[7:0];
            got.entry_offset = rsp_tdata[39:8];
            got.entry_size = rsp_tdata[71:40];
            got.file_time = rsp_tdata[135:72];
            got.header_length = rsp_tdata[167:136];
            got.error_code = rsp_tdata[169:168];
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected result kind=%0d data=%h", $realtime, got.kind,
                           rsp_tdata);
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%0t: mismatch exp kind=%0d nb=%h off=%h sz=%h ft=%h hl=%h err=%0d",
                              $realtime, want.kind, want.name_byte, want.entry_offset,
                              want.entry_size, want.file_time, want.header_length,
                              want.error_code);
                     $display("%0t:          got kind=%0d nb=%h off=%h sz=%h ft=%h hl=%h err=%0d",
                              $realtime, got.kind, got.name_byte, got.entry_offset,
                              got.entry_size, got.file_time, got.header_length,
                              got.error_code);
                  end
               end
            end
         end
      end
   end

   function automatic void queue_byte(input logic [7:0] plain);
      byte_request_type item;
      item.data = plain ^ cfg_key;
      item.eoi = 1'b0;
      archive_bytes.insert(archive_bytes.size(), item);
   endfunction

   function automatic void queue_word(input logic [31:0] w);
      for (int i = 0; i < 4; i++)
         queue_byte(w[8*i +: 8]);
   endfunction

   // moves the archive out, closed by end of input; returns requests added
   function automatic int flush_archive();
      byte_request_type item;
      int               n;
      n = archive_bytes.size() + 1;
      while (archive_bytes.size() != 0)
         pending_requests.insert(pending_requests.size(), archive_bytes.pop_front());
      item.data = 8'($urandom);
      item.eoi = 1'b1;
      pending_requests.insert(pending_requests.size(), item);
      return n;
   endfunction

   function automatic void queue_entry();
      int          name_len;
      logic [31:0] size;
      queue_byte(8'($urandom_range(127)));
      name_len = ($urandom_range(99) < 2) ? 255 : $urandom_range(6);
      queue_byte(8'(name_len));
      for (int i = 0; i < name_len; i++)
         queue_byte(8'($urandom));
      case ($urandom_range(7))
         0: size = 32'h7FFF_FFFF;
         1: size = 32'h8000_0000;
         2: size = 32'hFFFF_FFFF;
         3: size = 32'h0;
         default: size = $urandom;
      endcase
      queue_word(size);
      queue_word($urandom);
      queue_word($urandom);
   endfunction

   function automatic int build_archive();
      byte_request_type item;
      int               flavor;
      int               n;
      logic [31:0]      magic;
      logic [31:0]      ver;
      flavor = $urandom_range(99);
      archive_bytes.delete();
      if (flavor >= 32 && flavor < 37) begin
         n = $urandom_range(12, 1);
         for (int i = 0; i < n; i++) begin
            item.data = 8'($urandom);
            item.eoi = ($urandom_range(5) == 0);
            archive_bytes.insert(archive_bytes.size(), item);
         end
         return flush_archive();
      end
      magic = cfg_magic;
      if (flavor < 6)
         magic = magic ^ (32'd1 << $urandom_range(31));
      queue_word(magic);
      if (flavor >= 6 && flavor < 12 && cfg_max_ver != 32'hFFFF_FFFF) begin
         if ($urandom_range(1) == 0)
            ver = cfg_max_ver + 32'd1;
         else
            ver = $urandom_range(32'hFFFF_FFFF, cfg_max_ver + 32'd1);
      end else if ($urandom_range(2) == 0) begin
         ver = cfg_max_ver;
      end else begin
         ver = $urandom_range(cfg_max_ver, 0);
      end
      queue_word(ver);
      n = $urandom_range(4);
      for (int i = 0; i < n; i++)
         queue_entry();
      if (!(flavor >= 12 && flavor < 18)) begin
         queue_byte(8'h80 | 8'($urandom_range(127)));
         n = $urandom_range(2);
         for (int i = 0; i < n; i++)
            queue_byte(8'($urandom));
      end
      if (flavor >= 18 && flavor < 32) begin
         n = $urandom_range(archive_bytes.size() - 1, 0);
         while (archive_bytes.size() > n)
            void'(archive_bytes.pop_back());
      end
      return flush_archive();
   endfunction

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         adp_pkg::CSR_XOR_KEY:        cfg_key = value[7:0];
         adp_pkg::CSR_EXPECTED_MAGIC: cfg_magic = value;
         adp_pkg::CSR_MAX_VERSION:    cfg_max_ver = value;
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      do
         @(posedge clock);
      while (pending_requests.size() != 0 || req_tvalid || expected_results.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      int sent;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < 6; ph++) begin
         if (ph > 0) begin
            wait_drained();
            case (ph)
               1: begin
                  write_reg(adp_pkg::CSR_XOR_KEY, 32'h00);
                  write_reg(adp_pkg::CSR_EXPECTED_MAGIC, 32'h0);
                  write_reg(adp_pkg::CSR_MAX_VERSION, 32'hFFFF_FFFF);
               end
               2: begin
                  write_reg(adp_pkg::CSR_XOR_KEY, 32'hFF);
                  write_reg(adp_pkg::CSR_EXPECTED_MAGIC, 32'hFFFF_FFFF);
                  write_reg(adp_pkg::CSR_MAX_VERSION, 32'h0);
               end
               5: begin
                  write_reg(adp_pkg::CSR_XOR_KEY, 32'(adp_pkg::XOR_KEY_RESET));
                  write_reg(adp_pkg::CSR_EXPECTED_MAGIC, adp_pkg::MAGIC_RESET);
                  write_reg(adp_pkg::CSR_MAX_VERSION, 32'd1);
               end
               default: begin
                  write_reg(adp_pkg::CSR_XOR_KEY, 32'($urandom_range(255)));
                  write_reg(adp_pkg::CSR_EXPECTED_MAGIC, $urandom);
                  write_reg(adp_pkg::CSR_MAX_VERSION,
                            $urandom_range(32'hFFFF_FFFF, 0) >> $urandom_range(31));
               end
            endcase
         end
         if (ph < 2) begin
            send_idle_pct = 15;
            recv_stall_pct = 75;
         end else if (ph < 4) begin
            send_idle_pct = 75;
            recv_stall_pct = 15;
         end else begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         sent = 0;
         if (ph == 0) begin
            // empty stream, then one entry with extreme fields, a byte while idle
            sent += flush_archive();
            queue_word(cfg_magic);
            queue_word(cfg_max_ver);
            queue_byte(8'h7F);
            queue_byte(8'h01);
            queue_byte(8'hFF);
            queue_word(32'h8000_0000);
            queue_word(32'hFFFF_FFFF);
            queue_word(32'hFFFF_FFFF);
            queue_byte(8'h80);
            queue_byte(8'h00);
            sent += flush_archive();
         end
         while (sent < 295)
            sent += build_archive();
      end
      wait_drained();
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #500us;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== archive_directory_parser.f =====
hw/rtl/adp_pkg.sv
hw/rtl/adp_core.sv
hw/rtl/adp_out_buf.sv
hw/rtl/archive_directory_parser.sv
tb/archive_directory_parser_tb.sv
